/* hw/rtl/virtio_mmio_net_register_bank_defines.svh */
`ifndef VIRTIO_MMIO_NET_REGISTER_BANK_DEFINES_SVH
`define VIRTIO_MMIO_NET_REGISTER_BANK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define VMNRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define VMNRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/vmnrb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package vmnrb_pkg;

  localparam int NUM_QUEUES_DEF      = 2;
  localparam int MAX_QUEUE_DEPTH_DEF = 256;
  localparam int CFG_INDEX_W         = 4;

  localparam logic [1:0] REQ_READ     = 2'd0;
  localparam logic [1:0] REQ_WRITE    = 2'd1;
  localparam logic [1:0] REQ_EVENT    = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_OFFERED = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VENDOR  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAC     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GMEM    = 4'd3;

  localparam logic [8:0] OFF_MAGIC      = 9'h000;
  localparam logic [8:0] OFF_VERSION    = 9'h004;
  localparam logic [8:0] OFF_DEVICE_ID  = 9'h008;
  localparam logic [8:0] OFF_VENDOR_ID  = 9'h00c;
  localparam logic [8:0] OFF_DEV_FEAT   = 9'h010;
  localparam logic [8:0] OFF_DEV_FSEL   = 9'h014;
  localparam logic [8:0] OFF_DRV_FEAT   = 9'h020;
  localparam logic [8:0] OFF_DRV_FSEL   = 9'h024;
  localparam logic [8:0] OFF_QSEL       = 9'h030;
  localparam logic [8:0] OFF_QNUM_MAX   = 9'h034;
  localparam logic [8:0] OFF_QNUM       = 9'h038;
  localparam logic [8:0] OFF_QREADY     = 9'h044;
  localparam logic [8:0] OFF_QNOTIFY    = 9'h050;
  localparam logic [8:0] OFF_IRQ_STATUS = 9'h060;
  localparam logic [8:0] OFF_IRQ_ACK    = 9'h064;
  localparam logic [8:0] OFF_STATUS     = 9'h070;
  localparam logic [8:0] OFF_DESC_LO    = 9'h080;
  localparam logic [8:0] OFF_DESC_HI    = 9'h084;
  localparam logic [8:0] OFF_AVAIL_LO   = 9'h090;
  localparam logic [8:0] OFF_AVAIL_HI   = 9'h094;
  localparam logic [8:0] OFF_USED_LO    = 9'h0a0;
  localparam logic [8:0] OFF_USED_HI    = 9'h0a4;
  localparam logic [8:0] OFF_CONFIG     = 9'h100;
  localparam logic [8:0] OFF_CONFIG_END = 9'h106;
  localparam logic [9:0] WINDOW_BYTES   = 10'd512;

  localparam logic [63:0] MAGIC_VALUE  = 64'h7472_6976;
  localparam logic [63:0] VERSION_VAL  = 64'd2;
  localparam logic [63:0] DEVICE_NET   = 64'd1;
  localparam int          FEAT_V1_BIT  = 32;
  localparam logic [63:0] OFFERED_RESET = 64'h1_0000_0000;

  localparam int ST_BIT_DRV_READY   = 2;
  localparam int ST_BIT_FEATURES_OK = 3;
  localparam int ST_BIT_FAILED      = 7;

  localparam logic [1:0] CHK_HEADER = 2'd0;
  localparam logic [1:0] CHK_DESC   = 2'd1;
  localparam logic [1:0] CHK_AVAIL  = 2'd2;
  localparam logic [1:0] CHK_USED   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_IRQ, ST_EXEC, ST_START, ST_ACK, ST_OUT
  } fsm_state_t;

  typedef struct packed {
    logic [15:0] size;
    logic        en;
    logic [63:0] desc;
    logic [63:0] avail;
    logic [63:0] used;
    logic [15:0] acked;
    logic [15:0] seen;
  } queue_entry_t;

  typedef struct packed {
    logic clear;
    logic we_size;
    logic we_en;
    logic we_desc;
    logic we_avail;
    logic we_used;
    logic we_acked;
    logic we_seen;
  } queue_ctl_t;

  function automatic logic [63:0] set_half(logic [63:0] a, logic hi, logic [63:0] v);
    set_half = hi ? {v[31:0], a[31:0]} : {a[63:32], v[31:0]};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/virtio_mmio_net_register_bank.sv */
// Virtio-mmio v2 network register bank.
// Request channel (s_*): one beat per bus read, bus write or used-index
// event; s_tuser carries the request kind. Response channel (m_*): one beat
// per request with read data, the accept flag and the interrupt line.
// Configuration channel (cfg_*): always ready; write only while idle.
// An accepted request executes, then a walk over the queues refreshes the
// interrupt line and the response is loaded; an interrupt status read walks
// them first too, an interrupt acknowledge walks them again, and setting the
// driver-ready status bit adds each enabled queue's ring checks. One 64-bit
// range-compare unit is shared by all ring checks; the sequencer walks the
// queues through it one check per cycle, so the queue count sets the latency.
// One request is in flight at a time; s_tready is high only when idle, so
// a new request is taken only after the last one reaches the output register.
// A finished response is held in the output register until m_tready; the
// next request may be taken meanwhile but waits to finish until it drains.
// Reset clears all device state, restores the offered features to the
// version-one feature bit only, and clears the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
`include "virtio_mmio_net_register_bank_defines.svh"
module virtio_mmio_net_register_bank import vmnrb_pkg::*; #(
  parameter int NUM_QUEUES      = NUM_QUEUES_DEF,
  parameter int MAX_QUEUE_DEPTH = MAX_QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // offset[8:0], byte_count[12:9], write_data[76:13], event_queue[77],
  // used_index_value[93:78], zero fill[95:94]
  input  wire logic [95:0]            s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]             s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // read_data[63:0], accepted[64], irq_pending[65], zero fill[71:66]
  output logic [71:0]                 m_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_data
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [QW-1:0] LAST_Q = QW'(NUM_QUEUES - 1);

  fsm_state_t state, state_next;

  // latched request
  logic [1:0]  t_type;
  logic [8:0]  t_off;
  logic [3:0]  t_n;
  logic [63:0] t_wd;
  logic        t_eq;
  logic [15:0] t_ui;

  // configuration
  logic [63:0] offered;
  logic [31:0] vendor;
  logic [47:0] mac;
  logic [63:0] gmem;

  // device state
  logic [7:0]  status, status_next;
  logic [31:0] dev_fsel, dev_fsel_next;
  logic [31:0] drv_fsel, drv_fsel_next;
  logic [63:0] drv_bits, drv_bits_next;
  logic [31:0] qsel, qsel_next;
  logic        started, started_next;

  // sequencer
  logic          post, post_next;
  logic [QW-1:0] qcnt, qcnt_next;
  logic [1:0]    kstep, kstep_next;
  logic          any_ok, any_ok_next;
  logic          pend_acc, pend_acc_next;
  logic          pending, pending_next;
  logic [63:0]   rd, rd_next;
  logic          acc, acc_next;

  logic        out_valid, out_valid_next;
  logic [63:0] out_rd;
  logic        out_acc;
  logic        out_irq;
  logic        out_load;

  // queue file port
  logic [QW-1:0] qi;
  queue_ctl_t    qctl;
  queue_entry_t  qe, qwd;

  // shared range unit
  logic [63:0] fit_addr, fit_len;
  logic        fit_ok;

  // decode
  logic [9:0]  end_off;
  logic        acc_ok;
  logic [63:0] mask, wdm, read_val, mac_val;
  logic        sel_ok;
  logic [QW-1:0] qsel_idx, eq_idx;
  logic        eq_ok;
  logic        size_wr_ok, size_cur_ok, align_ok, feat_bad, last_q, pend_now;
  logic [7:0]  ns;
  logic [63:0] desc_len, avail_len, used_len;

  vmnrb_queue_file #(.NUM_QUEUES(NUM_QUEUES), .QW(QW)) u_queues (
    .clk   (clk),
    .rst   (rst),
    .idx   (qi),
    .ctl   (qctl),
    .wdata (qwd),
    .rdata (qe)
  );

  vmnrb_fits u_fits (
    .addr  (fit_addr),
    .len   (fit_len),
    .limit (gmem),
    .ok    (fit_ok)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {6'd0, out_irq, out_acc, out_rd};

  assign end_off  = {1'b0, t_off} + {6'd0, t_n};
  assign acc_ok   = (t_type == REQ_READ || t_type == REQ_WRITE) && (t_n != 4'd0) &&
                    (t_n <= 4'd8) && (end_off <= WINDOW_BYTES);
  assign mask     = (t_n >= 4'd8) ? '1 : ((64'd1 << {t_n, 3'b000}) - 64'd1);
  assign wdm      = t_wd & mask;
  assign sel_ok   = (qsel < 32'(NUM_QUEUES));
  assign qsel_idx = qsel[QW-1:0];
  assign eq_idx   = QW'(t_eq);
  assign eq_ok    = (32'(t_eq) < 32'(NUM_QUEUES));
  assign mac_val  = {16'd0, mac} >> {t_off[2:0], 3'b000};
  assign ns       = wdm[7:0];
  assign feat_bad = ((drv_bits & ~offered) != '0) || !drv_bits[FEAT_V1_BIT];

  assign size_wr_ok  = (wdm != '0) && (wdm <= 64'(MAX_QUEUE_DEPTH)) &&
                       ((wdm & (wdm - 64'd1)) == '0);
  assign size_cur_ok = (qe.size != '0) && (32'(qe.size) <= 32'(MAX_QUEUE_DEPTH)) &&
                       ((qe.size & (qe.size - 16'd1)) == '0);
  assign align_ok    = (qe.desc[3:0] == 4'd0) && !qe.avail[0] && (qe.used[1:0] == 2'd0);

  assign desc_len  = {44'd0, qe.size, 4'd0};
  assign avail_len = {47'd0, qe.size, 1'b0} + 64'd4;
  assign used_len  = {45'd0, qe.size, 3'd0} + 64'd4;

  assign last_q   = (qcnt == LAST_Q);
  assign pend_now = qe.en && fit_ok && (qe.seen != qe.acked);

  always_comb begin
    if (state == ST_START) begin
      unique case (kstep)
        CHK_DESC:  begin fit_addr = qe.desc;  fit_len = desc_len;  end
        CHK_AVAIL: begin fit_addr = qe.avail; fit_len = avail_len; end
        CHK_USED:  begin fit_addr = qe.used;  fit_len = used_len;  end
        default:   begin fit_addr = qe.used;  fit_len = 64'd4;     end
      endcase
    end else begin
      fit_addr = qe.used;
      fit_len  = 64'd4;
    end
  end

  always_comb begin
    if (t_off >= OFF_CONFIG && t_off < OFF_CONFIG_END) begin
      read_val = mac_val;
    end else begin
      unique case (t_off)
        OFF_MAGIC:      read_val = MAGIC_VALUE;
        OFF_VERSION:    read_val = VERSION_VAL;
        OFF_DEVICE_ID:  read_val = DEVICE_NET;
        OFF_VENDOR_ID:  read_val = {32'd0, vendor};
        OFF_DEV_FEAT:   read_val = (dev_fsel == 32'd0) ? {32'd0, offered[31:0]} :
                                   (dev_fsel == 32'd1) ? {32'd0, offered[63:32]} : '0;
        OFF_DEV_FSEL:   read_val = {32'd0, dev_fsel};
        OFF_DRV_FEAT:   read_val = (drv_fsel == 32'd0) ? {32'd0, drv_bits[31:0]} :
                                   (drv_fsel == 32'd1) ? {32'd0, drv_bits[63:32]} : '0;
        OFF_DRV_FSEL:   read_val = {32'd0, drv_fsel};
        OFF_QSEL:       read_val = {32'd0, qsel};
        OFF_QNUM_MAX:   read_val = sel_ok ? 64'(MAX_QUEUE_DEPTH) : '0;
        OFF_QNUM:       read_val = sel_ok ? {48'd0, qe.size} : '0;
        OFF_QREADY:     read_val = {63'd0, sel_ok && qe.en};
        OFF_IRQ_STATUS: read_val = {63'd0, pending};
        OFF_STATUS:     read_val = {56'd0, status};
        default:        read_val = '0;
      endcase
    end
  end

  always_comb begin
    state_next    = state;
    status_next   = status;
    dev_fsel_next = dev_fsel;
    drv_fsel_next = drv_fsel;
    drv_bits_next = drv_bits;
    qsel_next     = qsel;
    started_next  = started;
    post_next     = post;
    qcnt_next     = qcnt;
    kstep_next    = kstep;
    any_ok_next   = any_ok;
    pend_acc_next = pend_acc;
    pending_next  = pending;
    rd_next       = rd;
    acc_next      = acc;
    out_load      = 1'b0;
    qi            = qcnt;
    qctl          = '0;
    qwd           = qe;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          qcnt_next     = '0;
          pend_acc_next = 1'b0;
          post_next     = 1'b0;
          // interrupt status read needs a fresh walk first
          if (s_tuser == REQ_READ && s_tdata[8:0] == OFF_IRQ_STATUS) begin
            state_next = ST_IRQ;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end

      ST_IRQ: begin
        if (last_q) begin
          pending_next = pend_acc | pend_now;
          state_next   = post ? ST_OUT : ST_EXEC;
        end else begin
          pend_acc_next = pend_acc | pend_now;
          qcnt_next     = qcnt + QW'(1);
        end
      end

      ST_EXEC: begin
        qi            = (t_type == REQ_EVENT) ? eq_idx : qsel_idx;
        rd_next       = '0;
        acc_next      = 1'b0;
        state_next    = ST_IRQ;
        post_next     = 1'b1;
        qcnt_next     = '0;
        pend_acc_next = 1'b0;
        kstep_next    = CHK_DESC;
        any_ok_next   = 1'b0;
        if (t_type == REQ_EVENT) begin
          if (eq_ok) begin
            qctl.we_seen = 1'b1;
            qwd.seen     = t_ui;
            acc_next     = 1'b1;
          end
        end else if (acc_ok) begin
          acc_next = 1'b1;
          if (t_type == REQ_READ) begin
            rd_next = read_val & mask;
          end else begin
            unique case (t_off)
              OFF_DEV_FSEL: dev_fsel_next = wdm[31:0];
              OFF_DRV_FSEL: drv_fsel_next = wdm[31:0];
              OFF_DRV_FEAT: begin
                if (drv_fsel == 32'd0 || drv_fsel == 32'd1) begin
                  drv_bits_next = set_half(drv_bits, drv_fsel == 32'd1, wdm);
                end
              end
              OFF_QSEL: qsel_next = wdm[31:0];
              OFF_QNUM: begin
                if (sel_ok) begin
                  if (!size_wr_ok) begin
                    status_next[ST_BIT_FAILED] = 1'b1;
                  end else begin
                    qctl.we_size = 1'b1;
                    qwd.size     = wdm[15:0];
                  end
                end
              end
              OFF_QREADY: begin
                if (sel_ok) begin
                  if ((wdm[63:1] != '0) || started) begin
                    status_next[ST_BIT_FAILED] = 1'b1;
                  end else begin
                    qctl.we_en = 1'b1;
                    qwd.en     = wdm[0];
                  end
                end
              end
              OFF_DESC_LO, OFF_DESC_HI: begin
                if (sel_ok) begin
                  qctl.we_desc = 1'b1;
                  qwd.desc     = set_half(qe.desc, t_off == OFF_DESC_HI, wdm);
                end
              end
              OFF_AVAIL_LO, OFF_AVAIL_HI: begin
                if (sel_ok) begin
                  qctl.we_avail = 1'b1;
                  qwd.avail     = set_half(qe.avail, t_off == OFF_AVAIL_HI, wdm);
                end
              end
              OFF_USED_LO, OFF_USED_HI: begin
                if (sel_ok) begin
                  qctl.we_used = 1'b1;
                  qwd.used     = set_half(qe.used, t_off == OFF_USED_HI, wdm);
                end
              end
              OFF_QNOTIFY: begin
                if ((wdm >= 64'(NUM_QUEUES)) && status[ST_BIT_DRV_READY]) begin
                  status_next[ST_BIT_FAILED] = 1'b1;
                end
              end
              OFF_IRQ_ACK: begin
                if (wdm[0]) state_next = ST_ACK;
              end
              OFF_STATUS: begin
                if (ns == 8'd0) begin
                  qctl.clear    = 1'b1;
                  started_next  = 1'b0;
                  status_next   = '0;
                  dev_fsel_next = '0;
                  drv_fsel_next = '0;
                  drv_bits_next = '0;
                  qsel_next     = '0;
                end else begin
                  status_next = ns;
                  if (ns[ST_BIT_FEATURES_OK] && feat_bad) begin
                    status_next[ST_BIT_FAILED] = 1'b1;
                  end
                  if (status_next[ST_BIT_DRV_READY] && !status_next[ST_BIT_FAILED] &&
                      !started) begin
                    if (!drv_bits[FEAT_V1_BIT]) begin
                      status_next[ST_BIT_FAILED] = 1'b1;
                    end else begin
                      state_next = ST_START;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_ACK: begin
        if (qe.en && fit_ok) begin
          qctl.we_acked = 1'b1;
          qwd.acked     = qe.seen;
        end
        if (last_q) begin
          state_next = ST_IRQ;
          qcnt_next  = '0;
        end else begin
          qcnt_next = qcnt + QW'(1);
        end
      end

      ST_START: begin
        if (!qe.en) begin
          if (last_q) begin
            state_next = ST_IRQ;
            qcnt_next  = '0;
            if (any_ok) started_next = 1'b1;
            else status_next[ST_BIT_FAILED] = 1'b1;
          end else begin
            qcnt_next = qcnt + QW'(1);
          end
        end else begin
          unique case (kstep)
            CHK_DESC: begin
              if (size_cur_ok && align_ok && fit_ok) begin
                kstep_next = CHK_AVAIL;
              end else begin
                status_next[ST_BIT_FAILED] = 1'b1;
                state_next = ST_IRQ;
                qcnt_next  = '0;
              end
            end
            CHK_AVAIL: begin
              if (fit_ok) begin
                kstep_next = CHK_USED;
              end else begin
                status_next[ST_BIT_FAILED] = 1'b1;
                state_next = ST_IRQ;
                qcnt_next  = '0;
              end
            end
            CHK_USED: begin
              if (fit_ok) begin
                // ring fits, so its header does too: live index is the seen one
                qctl.we_acked = 1'b1;
                qwd.acked     = qe.seen;
                any_ok_next   = 1'b1;
                kstep_next    = CHK_DESC;
                if (last_q) begin
                  started_next = 1'b1;
                  state_next   = ST_IRQ;
                  qcnt_next    = '0;
                end else begin
                  qcnt_next = qcnt + QW'(1);
                end
              end else begin
                status_next[ST_BIT_FAILED] = 1'b1;
                state_next = ST_IRQ;
                qcnt_next  = '0;
              end
            end
            default: kstep_next = CHK_DESC;
          endcase
        end
      end

      ST_OUT: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    if (out_load) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      status    <= '0;
      dev_fsel  <= '0;
      drv_fsel  <= '0;
      drv_bits  <= '0;
      qsel      <= '0;
      started   <= 1'b0;
      post      <= 1'b0;
      qcnt      <= '0;
      kstep     <= CHK_DESC;
      any_ok    <= 1'b0;
      pend_acc  <= 1'b0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      status    <= status_next;
      dev_fsel  <= dev_fsel_next;
      drv_fsel  <= drv_fsel_next;
      drv_bits  <= drv_bits_next;
      qsel      <= qsel_next;
      started   <= started_next;
      post      <= post_next;
      qcnt      <= qcnt_next;
      kstep     <= kstep_next;
      any_ok    <= any_ok_next;
      pend_acc  <= pend_acc_next;
      pending   <= pending_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offered <= OFFERED_RESET;
      vendor  <= '0;
      mac     <= '0;
      gmem    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFERED: offered <= cfg_data;
        CFG_VENDOR:  vendor  <= cfg_data[31:0];
        CFG_MAC:     mac     <= cfg_data[47:0];
        CFG_GMEM:    gmem    <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold request and result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      t_type <= s_tuser;
      t_off  <= s_tdata[8:0];
      t_n    <= s_tdata[12:9];
      t_wd   <= s_tdata[76:13];
      t_eq   <= s_tdata[77];
      t_ui   <= s_tdata[93:78];
    end
    rd  <= rd_next;
    acc <= acc_next;
    if (out_load) begin
      out_rd  <= rd;
      out_acc <= acc;
      out_irq <= pending;
    end
  end

  `VMNRB_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready during work")
  `VMNRB_ASSERT_NOW(a_reject_reads_zero, out_valid && !out_acc, out_rd == '0, "data on reject")
  `VMNRB_ASSERT_NOW(a_rise_from_out, $rose(out_valid), $past(state) == ST_OUT, "stray result")

endmodule
`default_nettype wire

/* hw/rtl/vmnrb_fits.sv */
`timescale 1ns / 1ps
`default_nettype none
module vmnrb_fits import vmnrb_pkg::*; (
  input  wire logic [63:0] addr,
  input  wire logic [63:0] len,
  input  wire logic [63:0] limit,
  output logic             ok
);

  // Range [addr, addr+len) lies inside [0, limit) without wrapping.
  assign ok = (addr <= limit) && (len <= (limit - addr));

endmodule
`default_nettype wire

/* hw/rtl/vmnrb_queue_file.sv */
`timescale 1ns / 1ps
`default_nettype none
module vmnrb_queue_file import vmnrb_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [QW-1:0] idx,
  input  wire queue_ctl_t    ctl,
  input  wire queue_entry_t  wdata,
  output queue_entry_t       rdata
);

  queue_entry_t entries [NUM_QUEUES];

  assign rdata = entries[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        entries[i] <= '0;
      end
    end else if (ctl.clear) begin
      // status reset keeps the used index seen from the backend
      for (int i = 0; i < NUM_QUEUES; i++) begin
        entries[i].size  <= '0;
        entries[i].en    <= 1'b0;
        entries[i].desc  <= '0;
        entries[i].avail <= '0;
        entries[i].used  <= '0;
        entries[i].acked <= '0;
      end
    end else begin
      if (ctl.we_size)  entries[idx].size  <= wdata.size;
      if (ctl.we_en)    entries[idx].en    <= wdata.en;
      if (ctl.we_desc)  entries[idx].desc  <= wdata.desc;
      if (ctl.we_avail) entries[idx].avail <= wdata.avail;
      if (ctl.we_used)  entries[idx].used  <= wdata.used;
      if (ctl.we_acked) entries[idx].acked <= wdata.acked;
      if (ctl.we_seen)  entries[idx].seen  <= wdata.seen;
    end
  end

endmodule
`default_nettype wire
